// ===== sv/ipq_pkg.sv =====
// ----------------------------------------------------------------------------
// ipq_pkg
// Shared types and operation codes of the indexed priority queue.
// ----------------------------------------------------------------------------
package ipq_pkg;

    localparam int unsigned OP_W   = 3;
    localparam int unsigned ID_W   = 6;
    localparam int unsigned PRIO_W = 32;
    localparam int unsigned CNT_W  = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_RAISE  = 3'd1;
    localparam logic [OP_W-1:0] OP_LOWER  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP    = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

    typedef logic signed [PRIO_W-1:0] t_prio;

    // Input item: op | entry_id | priority_in, packed from the lowest bit up
    typedef struct packed {
        t_prio           priority_in;
        logic [ID_W-1:0] entry_id;
        logic [OP_W-1:0] op;
    } t_in_item;

    // Result item: ok | id_out | priority_out | count_out
    typedef struct packed {
        logic [CNT_W-1:0] count_out;
        t_prio            priority_out;
        logic [ID_W-1:0]  id_out;
        logic             ok;
    } t_out_item;

endpackage

// ===== sv/indexed_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// indexed_priority_queue_core
// Max priority queue indexed by entry id, held as a sorted id list in memory.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_axis_*) carries one operation per item: op in bits
//   [2:0], entry_id in [8:3], priority_in in [40:9]. Master channel
//   (m_axis_*) returns one result per item: ok [0], id_out [6:1],
//   priority_out [38:7], count_out [45:39].
//   One item is worked on at a time. The ordered id list lives in one
//   memory and the priority table in a second, both with a registered read,
//   so walking the list reads and then compares each visited entry, and
//   shifting it moves one entry per step. The next item can be accepted in
//   the cycle after the result loads. The result sits in an output register;
//   the next item is accepted as soon as the previous work is finished,
//   even while that result still waits to be taken, but the register must
//   drain before a new one loads. Reset clears the present bits and the
//   entry count; the memories need no clearing since their contents are
//   only used below the count or for present ids.
// ----------------------------------------------------------------------------
module indexed_priority_queue_core #(
    parameter int unsigned MAX_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // op[2:0], entry_id[8:3], priority_in[40:9]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // ok[0], id_out[6:1], priority_out[38:7],
                                        // count_out[45:39]
);
    import ipq_pkg::*;

    localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

    // Sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;  // key of entry_id read back
    localparam logic [3:0] S_FREAD = 4'd2;  // find: order read issued
    localparam logic [3:0] S_FCMP  = 4'd3;  // find: compare order word
    localparam logic [3:0] S_UNLNK = 4'd4;  // unlink: shift down
    localparam logic [3:0] S_PREAD = 4'd5;  // place: read key of order word
    localparam logic [3:0] S_PKEY  = 4'd6;  // place: compare key
    localparam logic [3:0] S_SHIFT = 4'd7;  // place: shift up
    localparam logic [3:0] S_POPK  = 4'd8;  // pop: top id read back
    localparam logic [3:0] S_POPP  = 4'd9;  // pop: key read back
    localparam logic [3:0] S_DONE  = 4'd10;
    localparam logic [3:0] S_UREAD = 4'd11; // unlink read wait

    // Memories
    logic [ID_W-1:0] order_mem [MAX_ENTRIES];
    t_prio           key_mem   [MAX_ENTRIES];
    logic [ID_W-1:0] r_order_q;
    t_prio           r_key_q;
    logic [AW-1:0]   ord_raddr, ord_waddr, key_raddr;
    logic            ord_we, key_we;
    logic [ID_W-1:0] ord_wdata;
    t_prio           key_wdata;
    logic [AW-1:0]   key_waddr;

    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            order_mem[ord_waddr] <= ord_wdata;
        end
        r_order_q <= order_mem[ord_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[key_waddr] <= key_wdata;
        end
        r_key_q <= key_mem[key_raddr];
    end

    // Control state
    logic [3:0]             r_state;
    logic [MAX_ENTRIES-1:0] r_present;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_pos;      // walk index
    logic [CW-1:0]          r_lim;      // place: insertion point
    t_in_item               r_in;
    logic                   r_valid_id;
    logic                   r_ok;       // operation succeeded
    logic [ID_W-1:0]        r_hold;     // id of the popped top entry
    logic                   r_m_valid;
    t_out_item              r_m_data;
    t_out_item              n_res;
    logic                   res_load;
    logic                   walk_more;

    logic [AW-1:0] id_idx;
    assign id_idx = AW'(r_in.entry_id);

    // Place walk goes on while the stored key is not strictly lower
    assign walk_more = (r_pos < r_count) && (r_key_q >= r_in.priority_in);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_m_data};

    // Memory port control
    always_comb begin
        ord_raddr = r_pos[AW-1:0];
        key_raddr = id_idx;
        ord_we    = 1'b0;
        ord_waddr = r_pos[AW-1:0];
        ord_wdata = r_hold;
        key_we    = 1'b0;
        key_waddr = id_idx;
        key_wdata = r_in.priority_in;
        case (r_state)
            S_IDLE:  key_raddr = AW'(s_axis_tdata[8:3]);
            S_PREAD: key_raddr = AW'(r_order_q);
            S_POPK:  key_raddr = AW'(r_order_q);
            S_PKEY: begin
                // next list word, or the last one ahead of the shift
                ord_raddr = walk_more ? AW'(r_pos + CW'(1)) : AW'(r_count - CW'(1));
            end
            S_UREAD: begin
                // head word for the place walk once the unlink is over
                if (r_pos >= r_count) begin
                    ord_raddr = '0;
                end
            end
            S_UNLNK: begin
                ord_we    = 1'b1;
                ord_waddr = AW'(r_pos - CW'(1));
                ord_wdata = r_order_q;
            end
            S_SHIFT: begin
                ord_we    = 1'b1;
                ord_waddr = r_pos[AW-1:0];
                ord_wdata = (r_pos == r_lim) ? r_in.entry_id : r_order_q;
                ord_raddr = AW'(r_pos - CW'(2));
                key_we    = (r_pos == r_lim);
            end
            default: ;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_present <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (res_load) begin
                r_m_valid <= 1'b1;
                r_m_data  <= n_res;
            end else if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_in       <= t_in_item'(s_axis_tdata[40:0]);
                        r_valid_id <= (32'(s_axis_tdata[8:3]) < MAX_ENTRIES);
                        r_ok       <= 1'b0;
                        r_pos      <= '0;
                        r_state    <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_pos <= '0;
                    case (r_in.op)
                        OP_INSERT: begin
                            if (r_valid_id && !r_present[id_idx]) begin
                                r_present[id_idx] <= 1'b1;
                                r_state <= (r_count == '0) ? S_PKEY : S_PREAD;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        OP_RAISE, OP_LOWER: begin
                            if (r_valid_id && r_present[id_idx] &&
                                ((r_in.op == OP_RAISE) ? (r_in.priority_in > r_key_q)
                                                       : (r_in.priority_in < r_key_q))) begin
                                r_state <= S_FREAD;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        OP_POP: begin
                            r_state <= (r_count == '0) ? S_DONE : S_POPK;
                        end
                        OP_QUERY: begin
                            r_ok    <= r_valid_id && r_present[id_idx];
                            r_state <= S_DONE;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_FREAD: r_state <= S_FCMP;
                S_FCMP: begin
                    if (r_order_q == r_in.entry_id) begin
                        r_pos   <= r_pos + CW'(1);
                        r_state <= S_UREAD;
                    end else begin
                        r_pos   <= r_pos + CW'(1);
                        r_state <= S_FREAD;
                    end
                end
                S_UREAD: begin
                    if (r_pos >= r_count) begin
                        r_count <= r_count - CW'(1);
                        r_pos   <= '0;
                        if (r_in.op == OP_POP) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= (r_count == CW'(1)) ? S_PKEY : S_PREAD;
                        end
                    end else begin
                        r_state <= S_UNLNK;
                    end
                end
                S_UNLNK: begin
                    r_pos   <= r_pos + CW'(1);
                    r_state <= S_UREAD;
                end
                S_PREAD: r_state <= S_PKEY;
                S_PKEY: begin
                    if (walk_more) begin
                        r_pos   <= r_pos + CW'(1);
                        r_state <= S_PREAD;
                    end else begin
                        r_lim   <= r_pos;
                        r_pos   <= r_count;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (r_pos == r_lim) begin
                        r_count <= r_count + CW'(1);
                        r_ok    <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_pos <= r_pos - CW'(1);
                    end
                end
                S_POPK: begin
                    r_hold  <= r_order_q;
                    r_state <= S_POPP;
                end
                S_POPP: begin
                    r_present[AW'(r_hold)] <= 1'b0;
                    r_in.priority_in <= r_key_q;
                    r_ok    <= 1'b1;
                    r_pos   <= CW'(1);
                    r_state <= S_UREAD;
                end
                S_DONE: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result formation
    always_comb begin
        res_load = (r_state == S_DONE) && (!r_m_valid || m_axis_tready);
        n_res.count_out    = 7'(r_count);
        n_res.id_out       = r_in.entry_id;
        n_res.priority_out = '0;
        n_res.ok           = r_ok;
        case (r_in.op)
            OP_POP: begin
                if (r_ok) begin
                    n_res.id_out       = r_hold;
                    n_res.priority_out = r_in.priority_in;
                end
            end
            OP_QUERY: begin
                if (r_ok) begin
                    n_res.priority_out = r_key_q;
                end
            end
            default: ;
        endcase
    end

    // Assertions
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES)) else $error("count overflow");
    a_count_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POPK) |-> (r_count != '0)) else $error("pop on empty");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");

endmodule
